@@ src/frr_pkg.sv @@
// Shared types, register indexes and constants of the flow rate reporter.
package frr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned THRESH_W   = 32;
  localparam int unsigned LITRES_W   = 48;
  localparam int unsigned RATE_W     = 48;
  localparam int unsigned DEN_W      = 2 * PERIOD_W;
  // Seconds per minute is folded in as x64 - x4, which needs six extra bits.
  localparam int unsigned MIN_EXT_W  = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_LITRE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP             = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PERIOD         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PERIOD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RATE_THRESHOLD = 3'd4;

  localparam logic [PERIOD_W-1:0] PPL_RESET         = 16'd450;
  localparam logic [PERIOD_W-1:0] MAX_GAP_RESET     = 16'd32;
  localparam logic [PERIOD_W-1:0] IDLE_PERIOD_RESET = 16'd30;
  localparam logic [PERIOD_W-1:0] ACT_PERIOD_RESET  = 16'd1;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET   = 32'd655;

  localparam logic [RATE_W-1:0] RATE_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [RATE_W-1:0] RATE_MIN = 48'h8000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_DECIDE,
    ST_DIVIDE,
    ST_FINISH
  } frr_state_e;

  typedef struct packed {
    logic load;
    logic gap;
    logic decide;
    logic finish;
  } frr_cmd_t;

  typedef struct packed {
    logic report;
    logic div_busy;
    logic out_free;
  } frr_sts_t;

endpackage

@@ src/frr_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module frr_div #(
  parameter int unsigned NUM_W = 54,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  assign busy_o    = (cnt_q != '0);
  assign quo_o     = quo_q;
  assign rem_shift = {rem_q, quo_q[NUM_W-1]};
  assign fits      = (rem_shift >= {1'b0, den_q});
  assign rem_sub   = rem_shift - {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - CNT_W'(1);
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

@@ src/frr_dp.sv @@
// Datapath: configuration, report state, gap and rate arithmetic, output register.
module frr_dp #(
  parameter int unsigned COUNT_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [frr_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [frr_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                  has_count_i,
  input  logic [31:0]                           pulse_total_i,
  input  logic [frr_pkg::TIME_W-1:0]            now_seconds_i,
  input  frr_pkg::frr_cmd_t                     cmd_i,
  output frr_pkg::frr_sts_t                     sts_o,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic [frr_pkg::TIME_W-1:0]            report_seconds_o,
  output logic [frr_pkg::LITRES_W-1:0]          litres_o,
  output logic signed [frr_pkg::RATE_W-1:0]     rate_o,
  output logic                                  is_flowing_o
);

  import frr_pkg::*;

  localparam int unsigned L_NUM_W = COUNT_BITS + FRACTION_BITS;
  localparam int unsigned M60_W   = COUNT_BITS + MIN_EXT_W;
  localparam int unsigned R_NUM_W = M60_W + FRACTION_BITS;

  // Configuration registers
  logic [PERIOD_W-1:0] ppl_q, max_gap_q, idle_period_q, act_period_q;
  logic [THRESH_W-1:0] threshold_q;

  // Report state
  logic [COUNT_BITS-1:0] current_count_q, reported_count_q;
  logic [TIME_W-1:0]     reported_time_q;
  logic [RATE_W-1:0]     reported_rate_q;
  logic                  flow_active_q;

  // Item stage registers
  logic [TIME_W-1:0]     now_q;
  logic [PERIOD_W-1:0]   gap_q;
  logic [COUNT_BITS-1:0] mag_q;
  logic                  cnt_neg_q;
  logic                  same_q;

  // Output register
  logic                  out_valid_q;
  logic [TIME_W-1:0]     out_seconds_q;
  logic [LITRES_W-1:0]   out_litres_q;
  logic [RATE_W-1:0]     out_rate_q;
  logic                  out_flowing_q;

  logic [TIME_W:0]       time_diff;
  logic                  resync;
  logic [PERIOD_W-1:0]   gap_eff;
  logic                  cnt_neg;
  logic [COUNT_BITS-1:0] mag;

  logic                  rate_hot;
  logic                  report_w;
  logic [PERIOD_W-1:0]   ppl_nz;
  logic [DEN_W-1:0]      rate_den;
  logic [M60_W-1:0]      mag60;
  logic [R_NUM_W-1:0]    rate_num;
  logic [L_NUM_W-1:0]    litres_num;
  logic                  div_start;

  logic                  lit_busy, rate_busy;
  logic [L_NUM_W-1:0]    lit_quo;
  logic [R_NUM_W-1:0]    rate_quo;
  logic [63:0]           rate_quo_x;
  logic                  rate_over;
  logic [RATE_W-1:0]     rate_mag;
  logic [RATE_W-1:0]     rate_sat;
  logic [RATE_W-1:0]     rate_rep;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppl_q         <= PPL_RESET;
      max_gap_q     <= MAX_GAP_RESET;
      idle_period_q <= IDLE_PERIOD_RESET;
      act_period_q  <= ACT_PERIOD_RESET;
      threshold_q   <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PULSES_PER_LITRE:    ppl_q         <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_MAX_GAP:             max_gap_q     <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_IDLE_PERIOD:         idle_period_q <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_ACTIVE_PERIOD:       act_period_q  <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_IDLE_RATE_THRESHOLD: threshold_q   <= cfg_wdata_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Gap stage: signed gap and resync, count difference
  assign time_diff = {1'b0, now_q} - {1'b0, reported_time_q};
  assign resync    = time_diff[TIME_W] ||
                     (time_diff[TIME_W-1:0] > {{(TIME_W-PERIOD_W){1'b0}}, max_gap_q});
  assign gap_eff   = resync ? '0 : time_diff[PERIOD_W-1:0];
  assign cnt_neg   = (current_count_q < reported_count_q);
  assign mag       = cnt_neg ? (reported_count_q - current_count_q)
                             : (current_count_q - reported_count_q);

  // Decide stage
  assign rate_hot = $signed({reported_rate_q[RATE_W-1], reported_rate_q}) >
                    $signed({{(RATE_W+1-THRESH_W){1'b0}}, threshold_q});
  assign report_w = same_q ? ((gap_q > idle_period_q) || rate_hot)
                           : (gap_q > act_period_q);
  assign ppl_nz     = (ppl_q == '0) ? PERIOD_W'(1) : ppl_q;
  assign rate_den   = DEN_W'(ppl_nz) * DEN_W'(gap_q);
  // x60 = x64 - x4
  assign mag60      = {mag_q, 6'b0} - {4'b0, mag_q, 2'b0};
  assign rate_num   = {mag60, {FRACTION_BITS{1'b0}}};
  assign litres_num = {current_count_q, {FRACTION_BITS{1'b0}}};
  assign div_start  = cmd_i.decide && report_w;

  frr_div #(
    .NUM_W(L_NUM_W),
    .DEN_W(PERIOD_W)
  ) u_lit_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (litres_num),
    .den_i  (ppl_nz),
    .busy_o (lit_busy),
    .quo_o  (lit_quo)
  );

  frr_div #(
    .NUM_W(R_NUM_W),
    .DEN_W(DEN_W)
  ) u_rate_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (rate_num),
    .den_i  (rate_den),
    .busy_o (rate_busy),
    .quo_o  (rate_quo)
  );

  // Saturate the rate quotient and apply the sign of the count difference
  assign rate_quo_x = 64'(rate_quo);
  assign rate_over  = (rate_quo_x > 64'(RATE_MAX));
  assign rate_mag   = rate_quo_x[RATE_W-1:0];
  assign rate_sat   = cnt_neg_q ? (rate_over ? RATE_MIN : (~rate_mag + RATE_W'(1)))
                                : (rate_over ? RATE_MAX : rate_mag);
  assign rate_rep   = same_q ? '0 : rate_sat;

  // Report state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_count_q  <= '0;
      reported_count_q <= '0;
      reported_time_q  <= '0;
      reported_rate_q  <= '0;
      flow_active_q    <= 1'b0;
    end else begin
      if (cmd_i.load && has_count_i) begin
        current_count_q <= pulse_total_i[COUNT_BITS-1:0];
      end
      if (cmd_i.gap && resync) begin
        reported_time_q <= now_q;
      end
      if (cmd_i.decide) begin
        flow_active_q <= !same_q;
      end
      if (cmd_i.finish) begin
        reported_time_q  <= now_q;
        reported_count_q <= current_count_q;
        reported_rate_q  <= rate_rep;
      end
    end
  end

  // Item stage registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= now_seconds_i;
    end
    if (cmd_i.gap) begin
      gap_q     <= gap_eff;
      mag_q     <= mag;
      cnt_neg_q <= cnt_neg;
      same_q    <= (current_count_q == reported_count_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_seconds_q <= now_q;
      out_litres_q  <= LITRES_W'(lit_quo);
      out_rate_q    <= rate_rep;
      out_flowing_q <= flow_active_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign report_seconds_o = out_seconds_q;
  assign litres_o         = out_litres_q;
  assign rate_o           = $signed(out_rate_q);
  assign is_flowing_o     = out_flowing_q;

  assign sts_o.report   = report_w;
  assign sts_o.div_busy = lit_busy || rate_busy;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  a_idle_zero_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_flowing_o) |-> (rate_o == '0))
    else $error("idle report carries a nonzero rate");

  a_finish_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (reported_time_q == report_seconds_o) &&
                     (reported_rate_q == out_rate_q))
    else $error("report state and output register disagree after a report");

  a_load_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !(lit_busy || rate_busy))
    else $error("item taken while the dividers are still running");

endmodule

@@ src/frr_ctrl.sv @@
// Controller: sequences one item through gap, decision, division and report.
module frr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  frr_pkg::frr_sts_t sts_i,
  output frr_pkg::frr_cmd_t cmd_o
);

  import frr_pkg::*;

  frr_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_GAP;
      ST_GAP:    state_d = ST_DECIDE;
      ST_DECIDE: state_d = sts_i.report ? ST_DIVIDE : ST_IDLE;
      ST_DIVIDE: if (!sts_i.div_busy) state_d = ST_FINISH;
      ST_FINISH: if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_GAP:    cmd_o.gap    = 1'b1;
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_DIVIDE: ;
      ST_FINISH: cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/flow_rate_reporter_unit.sv @@
// Top level of the flow rate reporter: controller, datapath and ports.
//
// Each transfer on the input channel is one sensor event (a new pulse total
// or a timeout) stamped with the time in seconds; each transfer on the output
// channel is one volume and rate report, and an event causes at most one.
// An event that gives no report passes through the gap and decision states and
// back to idle. An event that gives a report also waits in the division state
// for the bit-serial divider that forms the rate quotient one bit per cycle;
// volume is divided alongside it. A finished report waits in the output
// register, and the next event is taken while it waits, but a further report
// waits for that register to drain. Configuration registers must be written
// through the write port only while the block is idle, which the block itself
// does not enforce; they have no read-back.
module flow_rate_reporter_unit #(
  parameter int unsigned COUNT_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [frr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [frr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Event channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              has_count_i,
  input  logic [31:0]                       pulse_total_i,
  input  logic [frr_pkg::TIME_W-1:0]        now_seconds_i,
  // Report channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [frr_pkg::TIME_W-1:0]        report_seconds_o,
  output logic [frr_pkg::LITRES_W-1:0]      litres_o,
  output logic signed [frr_pkg::RATE_W-1:0] rate_o,
  output logic                              is_flowing_o
);

  import frr_pkg::*;

  frr_cmd_t cmd;
  frr_sts_t sts;

  // Step one event at a time through the datapath
  frr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Hold configuration and report state, do the arithmetic, drive reports
  frr_dp #(
    .COUNT_BITS   (COUNT_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .has_count_i     (has_count_i),
    .pulse_total_i   (pulse_total_i),
    .now_seconds_i   (now_seconds_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .report_seconds_o(report_seconds_o),
    .litres_o        (litres_o),
    .rate_o          (rate_o),
    .is_flowing_o    (is_flowing_o)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the flow rate reporter: predicts each report and compares it.
module testbench;
  import frr_pkg::*;

  localparam int unsigned CNT_BITS     = 32;
  localparam int unsigned FRAC_BITS    = 16;
  // Covers a report in the divider, with margin.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam bit          EV_COUNT     = 1'b1;
  localparam bit          EV_TIMEOUT   = 1'b0;

  typedef struct {
    bit        has_count;
    bit [31:0] pulse_total;
    bit [31:0] now;
    bit        hold;        // hold the event back until every report is in
  } sensor_ev_t;

  typedef struct {
    bit [31:0] seconds;
    bit [47:0] litres;
    bit [47:0] rate;
    bit        flowing;
  } flow_report_t;

  // Block ports; every input starts at a known value.
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic                  has_count_i   = 1'b0;
  logic [31:0]           pulse_total_i = '0;
  logic [TIME_W-1:0]     now_seconds_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [TIME_W-1:0]     report_seconds_o;
  logic [LITRES_W-1:0]   litres_o;
  logic signed [RATE_W-1:0] rate_o;
  logic                  is_flowing_o;

  flow_rate_reporter_unit #(
    .COUNT_BITS   (CNT_BITS),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (.*);

  always #5 clk_i = ~clk_i;

  // Register copies used by the predictor.
  bit [15:0] ppl_reg      = PPL_RESET;
  bit [15:0] max_gap_reg  = MAX_GAP_RESET;
  bit [15:0] idle_reg     = IDLE_PERIOD_RESET;
  bit [15:0] active_reg   = ACT_PERIOD_RESET;
  bit [31:0] thresh_reg   = THRESHOLD_RESET;

  // Predictor state, all zero after reset.
  bit [CNT_BITS-1:0]  cur_count     = '0;
  bit [CNT_BITS-1:0]  rep_count     = '0;
  bit [31:0]          rep_time      = '0;
  logic signed [47:0] rep_rate      = '0;
  bit                 flowing_state = 1'b0;

  sensor_ev_t   pending_events[$];
  flow_report_t expected_reports[$];
  sensor_ev_t   drv_ev;
  flow_report_t drv_rep;

  int unsigned events_queued   = 0;
  int unsigned events_sent     = 0;
  int unsigned send_gap        = 0;
  int unsigned stall_left      = 0;
  int unsigned calm_timer      = 0;
  bit          calm            = 1'b0;
  int unsigned error_count     = 0;
  int unsigned reports_flowing = 0;
  int unsigned reports_idle    = 0;
  int unsigned rates_saturated = 0;
  int unsigned settings_run    = 1;

  // Traffic generator state: a plausible sensor with its own clock and count.
  bit [31:0] gen_time    = 32'd2000;
  bit [31:0] gen_count   = '0;
  bit        gen_flowing = 1'b0;

  // Work out the report that one event causes, if any, and advance the state.
  function automatic bit flow_report_of(input sensor_ev_t ev, output flow_report_t rep);
    logic signed [63:0] gap;
    bit [63:0] ppl, mag, num, quo;
    bit        neg;
    if (ev.has_count) cur_count = ev.pulse_total[CNT_BITS-1:0];
    ppl = (ppl_reg == 16'd0) ? 64'd1 : {48'd0, ppl_reg};
    // Resync on a clock that went backwards or a gap too long to trust.
    gap = $signed({32'd0, ev.now}) - $signed({32'd0, rep_time});
    if (gap < 0 || gap > $signed({48'd0, max_gap_reg})) begin
      gap = 0;
      rep_time = ev.now;
    end
    quo = ({32'd0, cur_count} << FRAC_BITS) / ppl;
    rep.seconds = ev.now;
    rep.litres  = quo[47:0];
    rep.rate    = '0;
    rep.flowing = 1'b0;
    if (cur_count == rep_count) begin
      flowing_state = 1'b0;
      // Report a stop at once when the last rate was above the threshold.
      if (gap > $signed({48'd0, idle_reg}) || rep_rate > $signed({32'd0, thresh_reg})) begin
        rep_time  = ev.now;
        rep_count = cur_count;
        rep_rate  = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    flowing_state = 1'b1;
    if (gap <= $signed({48'd0, active_reg})) return 1'b0;
    // Litres per minute, truncated toward zero, saturated to 48 bits.
    neg = cur_count < rep_count;
    mag = {32'd0, neg ? rep_count - cur_count : cur_count - rep_count};
    num = (mag * 64'd60) << FRAC_BITS;
    quo = num / (ppl * $unsigned(gap));
    if (quo > {16'd0, RATE_MAX}) begin
      rates_saturated++;
      rep.rate = neg ? RATE_MIN : RATE_MAX;
    end else begin
      quo = neg ? -quo : quo;
      rep.rate = quo[47:0];
    end
    rep.flowing = flowing_state;
    rep_time  = ev.now;
    rep_count = cur_count;
    rep_rate  = $signed(rep.rate);
    return 1'b1;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 16);
    return $urandom_range(17, 70);
  endfunction

  // Switch between stretches with random idling and stretches without any.
  always @(posedge clk_i) begin
    calm_timer++;
    if (calm_timer % 200 == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  // Event driver: predict at each transfer, then present the next pending event.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (flow_report_of(drv_ev, drv_rep)) expected_reports.push_back(drv_rep);
        events_sent++;
      end
      // Hold the payload while stalled; otherwise advance.
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_events.size() != 0 &&
                     !(pending_events[0].hold && expected_reports.size() != 0)) begin
          drv_ev = pending_events.pop_front();
          has_count_i   <= drv_ev.has_count;
          pulse_total_i <= drv_ev.pulse_total;
          now_seconds_i <= drv_ev.now;
          in_valid_i    <= 1'b1;
          send_gap = calm ? 0 : idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Compare one report transfer with the oldest expectation.
  task automatic check_report();
    flow_report_t want;
    if (expected_reports.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: report with none expected: seconds %0d litres %h rate %h flowing %0b",
                 $time, report_seconds_o, litres_o, rate_o, is_flowing_o);
      return;
    end
    want = expected_reports.pop_front();
    if (want.flowing) reports_flowing++;
    else reports_idle++;
    if (report_seconds_o !== want.seconds || litres_o !== want.litres ||
        rate_o !== want.rate || is_flowing_o !== want.flowing) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: report mismatch (expected/actual): seconds %0d/%0d litres %h/%h",
                 $time, want.seconds, report_seconds_o, want.litres, litres_o,
                 "\n    rate %h/%h flowing %0b/%0b",
                 want.rate, rate_o, want.flowing, is_flowing_o);
    end
  endtask

  // Report monitor with random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_report();
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = idle_len();
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_event(input bit has, input bit [31:0] total, input bit [31:0] now,
                            input bit hold);
    sensor_ev_t ev;
    ev.has_count   = has;
    ev.pulse_total = total;
    ev.now         = now;
    ev.hold        = hold;
    pending_events.push_back(ev);
    events_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_PULSES_PER_LITRE:    ppl_reg     = data[15:0];
      CFG_MAX_GAP:             max_gap_reg = data[15:0];
      CFG_IDLE_PERIOD:         idle_reg    = data[15:0];
      CFG_ACTIVE_PERIOD:       active_reg  = data[15:0];
      CFG_IDLE_RATE_THRESHOLD: thresh_reg  = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Write all registers; fill the unused upper bits of the 16-bit ones with junk.
  task automatic set_config(input bit [15:0] ppl, input bit [15:0] gap_max,
                            input bit [15:0] idle_s, input bit [15:0] act_s,
                            input bit [31:0] thr);
    bit [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    write_reg(CFG_PULSES_PER_LITRE, {junk, ppl});
    junk = 16'($urandom_range(0, 65535));
    write_reg(CFG_MAX_GAP, {junk, gap_max});
    junk = 16'($urandom_range(0, 65535));
    write_reg(CFG_IDLE_PERIOD, {junk, idle_s});
    junk = 16'($urandom_range(0, 65535));
    write_reg(CFG_ACTIVE_PERIOD, {junk, act_s});
    write_reg(CFG_IDLE_RATE_THRESHOLD, thr);
    settings_run++;
  endtask

  // Wait for every event to transfer and every report to arrive, then let the
  // block finish any event that causes no report.
  task automatic settle();
    while (events_sent != events_queued) @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly sensor-like traffic, plus count glitches, clock jumps and noise.
  task automatic queue_traffic(input int unsigned n);
    int unsigned pick;
    bit [31:0]   ppl_eff, total;
    bit          has;
    ppl_eff = (ppl_reg == 16'd0) ? 32'd1 : {16'd0, ppl_reg};
    repeat (n) begin
      pick  = $urandom_range(0, 99);
      has   = EV_COUNT;
      total = gen_count;
      if (pick < 75) begin
        if ($urandom_range(0, 11) == 0) gen_flowing = !gen_flowing;
        if ($urandom_range(0, 3) == 0) gen_time += $urandom_range(0, idle_reg + 2);
        else gen_time += $urandom_range(0, active_reg + 2);
        has = gen_flowing ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 2) == 0);
        if (has && gen_flowing) gen_count += $urandom_range(1, 2 * ppl_eff + 5);
        total = has ? gen_count : $urandom();
      end else if (pick < 85) begin
        gen_time += $urandom_range(0, idle_reg + max_gap_reg + 2);
        has   = EV_TIMEOUT;
        total = $urandom();
      end else if (pick < 92) begin
        // Counter glitch: step back a little or jump anywhere.
        if ($urandom_range(0, 1) == 0) gen_count -= $urandom_range(1, 4000);
        else gen_count = $urandom();
        gen_time += $urandom_range(0, active_reg + 3);
        total = gen_count;
      end else if (pick < 96) begin
        // Clock trouble: step back or jump anywhere.
        if ($urandom_range(0, 1) == 0) gen_time -= $urandom_range(1, 100);
        else gen_time = $urandom();
        has = 1'($urandom_range(0, 1));
      end else begin
        has   = 1'($urandom_range(0, 1));
        total = $urandom();
      end
      push_event(has, total, (pick >= 96) ? $urandom() : gen_time,
                 $urandom_range(0, 99) == 0);
    end
  endtask

  initial begin
    bit [15:0] ppl, gap_max, idle_s, act_s;
    bit [31:0] thr;
    int unsigned pick;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero start, idle report, flowing report, stop above the
    // threshold, count going backwards, clock going backwards and wrapping.
    push_event(EV_COUNT,   32'd0,          32'd0,          1'b0);
    push_event(EV_TIMEOUT, 32'hA5A5_5A5A,  32'd31,         1'b0);
    push_event(EV_COUNT,   32'd450,        32'd33,         1'b0);
    push_event(EV_TIMEOUT, 32'd0,          32'd34,         1'b0);
    push_event(EV_COUNT,   32'd900,        32'd35,         1'b0);
    push_event(EV_COUNT,   32'd1350,       32'd37,         1'b0);
    push_event(EV_TIMEOUT, 32'h5A5A_A5A5,  32'd200,        1'b0);
    push_event(EV_COUNT,   32'd100,        32'd203,        1'b0);
    push_event(EV_TIMEOUT, 32'd0,          32'd204,        1'b0);
    push_event(EV_COUNT,   32'd300,        32'd150,        1'b0);
    push_event(EV_COUNT,   32'hFFFF_FFFF,  32'd152,        1'b0);
    push_event(EV_TIMEOUT, 32'd0,          32'hFFFF_FFFF,  1'b1);
    push_event(EV_TIMEOUT, 32'd0,          32'd0,          1'b0);
    push_event(EV_COUNT,   32'hFFFF_FFFF,  32'd31,         1'b0);
    settle();

    // Low extremes: one pulse per litre, zero periods and threshold; drive the
    // rate into positive and negative saturation, then resync past max_gap.
    set_config(16'd1, 16'hFFFF, 16'd0, 16'd0, 32'd0);
    push_event(EV_COUNT,   32'd0,          32'd1000,       1'b0);
    push_event(EV_COUNT,   32'd0,          32'd1001,       1'b0);
    push_event(EV_COUNT,   32'hFFFF_FFFF,  32'd1002,       1'b0);
    push_event(EV_COUNT,   32'd0,          32'd1003,       1'b0);
    push_event(EV_TIMEOUT, 32'd0,          32'd1003,       1'b0);
    push_event(EV_COUNT,   32'd5,          32'd1003,       1'b0);
    push_event(EV_COUNT,   32'd7,          32'd66539,      1'b0);
    queue_traffic(100);
    settle();

    // High extremes, then zero pulses per litre, then the reset values again.
    set_config(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_traffic(40);
    settle();
    set_config(16'd0, 16'hFFFF, 16'd10, 16'd2, 32'd0);
    queue_traffic(110);
    settle();
    set_config(PPL_RESET, MAX_GAP_RESET, IDLE_PERIOD_RESET, ACT_PERIOD_RESET,
               THRESHOLD_RESET);
    queue_traffic(110);
    settle();

    for (int p = 0; p < 7; p++) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) ppl = 16'($urandom_range(1, 20));
      else if (pick == 1) ppl = 16'($urandom_range(1, 1000));
      else ppl = 16'($urandom_range(0, 65535));
      gap_max = 16'($urandom_range(0, 120));
      idle_s  = 16'($urandom_range(0, 60));
      act_s   = 16'($urandom_range(0, 8));
      pick = $urandom_range(0, 2);
      if (pick == 0) thr = '0;
      else if (pick == 1) thr = $urandom_range(0, 2000);
      else thr = $urandom();
      set_config(ppl, gap_max, idle_s, act_s, thr);
      queue_traffic(115);
      settle();
    end

    $display("Sent %0d events over %0d register settings; checked %0d flowing and %0d idle",
             events_sent, settings_run, reports_flowing, reports_idle);
    $display("reports, %0d with a saturated rate; %0d errors, %0d reports outstanding.",
             rates_saturated, error_count, expected_reports.size());
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d reports still expected", expected_reports.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
src/frr_pkg.sv
src/frr_div.sv
src/frr_dp.sv
src/frr_ctrl.sv
src/flow_rate_reporter_unit.sv
tb/testbench.sv
